### hw/rtl/bbq_pkg.sv
// ----------------------------------------------------------------------------
// bbq_pkg: shared types and constants of the bounded blocking queue
// Request and result codes, ring command struct and output buffer sizing.
// ----------------------------------------------------------------------------
package bbq_pkg;

  // Capacity register
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes; the fourth code is rejected
  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_PEEK = 2'd2
  } req_type_t;

  // Result codes
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_REJECT = 2'd3
  } result_kind_t;

  // Push/pop command to one ring buffer
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Result buffer: room for two results of one item plus slack
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

endpackage

### hw/rtl/bbq_ifs.sv
// ----------------------------------------------------------------------------
// bbq_ifs: channel interfaces of the bounded blocking queue
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbq_req_if #(
  parameter int DATA_WIDTH = 64,
  parameter int TAG_WIDTH  = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [DATA_WIDTH-1:0] item_data;
  logic [TAG_WIDTH-1:0]  op_tag;

  modport source (output valid, req_type, item_data, op_tag, input ready);
  modport sink   (input valid, req_type, item_data, op_tag, output ready);
endinterface

interface bbq_res_if #(
  parameter int DATA_WIDTH = 64,
  parameter int TAG_WIDTH  = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            result_kind;
  logic [TAG_WIDTH-1:0]  result_tag;
  logic [DATA_WIDTH-1:0] result_data;
  logic                  peek_found;
  logic                  last_result;

  modport source (output valid, result_kind, result_tag, result_data, peek_found,
                  last_result, input ready);
  modport sink   (input valid, result_kind, result_tag, result_data, peek_found,
                  last_result, output ready);
endinterface

interface bbq_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

### hw/rtl/bbq_ram.sv
// ----------------------------------------------------------------------------
// bbq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bbq_ring.sv
// ----------------------------------------------------------------------------
// bbq_ring: ring buffer with head prefetch
// Head pointer and fill count in flops, entries in RAM. The RAM is read at
// the next head every cycle, so the head entry is ready in the cycle after.
// ----------------------------------------------------------------------------
module bbq_ring
  import bbq_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ring_cmd_t                      cmd,
  input  logic [WIDTH-1:0]               push_data,
  output logic [WIDTH-1:0]               head_data,
  output logic [$clog2(DEPTH + 1)-1:0]   count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [IDX_W-1:0] wr_addr;
  logic [WIDTH-1:0] ram_rd;
  logic             byp;
  logic [WIDTH-1:0] byp_data;

  // Tail address, wrapped once
  assign tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign tail_wrap = (tail_sum >= (CNT_W + 1)'(DEPTH)) ?
                     tail_sum - (CNT_W + 1)'(DEPTH) : tail_sum;
  assign wr_addr   = tail_wrap[IDX_W-1:0];

  // Next head
  assign head_inc  = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_next = cmd.pop ? head_inc : head;

  // Pointer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      byp   <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
      byp   <= cmd.push && (wr_addr == head_next);
    end
  end

  // Write landing on the new head bypasses the RAM read
  always_ff @(posedge clk) begin
    byp_data <= push_data;
  end

  bbq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata (push_data),
    .raddr (head_next),
    .rdata (ram_rd)
  );

  assign head_data = byp ? byp_data : ram_rd;

endmodule

### hw/rtl/bbq_res_fifo.sv
// ----------------------------------------------------------------------------
// bbq_res_fifo: result buffer
// Small FIFO taking up to two results per cycle and giving one per handshake.
// ----------------------------------------------------------------------------
module bbq_res_fifo
  import bbq_pkg::*;
#(
  parameter int WIDTH = 76
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_n,
  input  logic [WIDTH-1:0] wr0,
  input  logic [WIDTH-1:0] wr1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0]     entries [RES_DEPTH];
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_CNT_W-1:0] count;
  logic [RES_CNT_W-1:0] count_after;
  logic                 pop;

  assign out_valid   = (count != '0);
  assign pop         = out_valid && out_ready;
  assign out_data    = entries[rd_ptr];
  assign count_after = count - RES_CNT_W'(pop);
  // Two free slots needed for one item's results
  assign room        = (count_after <= RES_CNT_W'(RES_DEPTH - 2));

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      wr_ptr <= wr_ptr + RES_PTR_W'(wr_n);
      count  <= count_after + RES_CNT_W'(wr_n);
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      entries[wr_ptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      entries[wr_ptr + 1'b1] <= wr1;
    end
  end

endmodule

### hw/rtl/bbq_ctrl.sv
// ----------------------------------------------------------------------------
// bbq_ctrl: request register and queue control
// Holds one request, decides it combinationally against the ring heads and
// counts, updates the rings and hands up to two results to the buffer.
// ----------------------------------------------------------------------------
module bbq_ctrl
  import bbq_pkg::*;
#(
  parameter int QUEUE_MAX    = 16,
  parameter int PRODUCER_MAX = 8,
  parameter int CONSUMER_MAX = 8,
  parameter int DATA_WIDTH   = 64,
  parameter int TAG_WIDTH    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [CAP_W-1:0]                     capacity,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [1:0]                           req_type,
  input  logic [DATA_WIDTH-1:0]                item_data,
  input  logic [TAG_WIDTH-1:0]                 op_tag,
  input  logic                                 room,
  output logic [1:0]                           res_n,
  output logic [DATA_WIDTH+TAG_WIDTH+3:0]      res0,
  output logic [DATA_WIDTH+TAG_WIDTH+3:0]      res1
);

  localparam int STORE_DEPTH = QUEUE_MAX + PRODUCER_MAX;
  localparam int IC_W        = $clog2(STORE_DEPTH + 1);
  localparam int PC_W        = $clog2(PRODUCER_MAX + 1);
  localparam int GC_W        = $clog2(CONSUMER_MAX + 1);

  // Request register
  logic                  in_v;
  logic [1:0]            type_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [TAG_WIDTH-1:0]  tag_q;
  logic                  fire;

  // Ring state
  ring_cmd_t             item_cmd, pw_cmd, gw_cmd;
  ring_cmd_t             item_req, pw_req, gw_req;
  logic [DATA_WIDTH-1:0] item_head;
  logic [TAG_WIDTH-1:0]  pw_head;
  logic [TAG_WIDTH-1:0]  gw_head;
  logic [IC_W-1:0]       i_cnt;
  logic [PC_W-1:0]       pw_cnt;
  logic [GC_W-1:0]       gw_cnt;

  // Decision
  logic [IC_W-1:0]       cap_eff;
  logic                  at_cap;
  logic                  g_wait;
  logic [1:0]            n;
  result_kind_t          k0, k1;
  logic [TAG_WIDTH-1:0]  t0, t1;
  logic [DATA_WIDTH-1:0] d0, d1;
  logic                  f0;

  assign fire      = in_v && room;
  assign req_ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (req_valid && req_ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      type_q <= req_type;
      data_q <= item_data;
      tag_q  <= op_tag;
    end
  end

  // Effective capacity: zero acts as one, clipped at QUEUE_MAX
  always_comb begin
    if (capacity == '0) begin
      cap_eff = IC_W'(1);
    end else if (32'(capacity) > 32'(QUEUE_MAX)) begin
      cap_eff = IC_W'(QUEUE_MAX);
    end else begin
      cap_eff = IC_W'(capacity);
    end
  end

  assign at_cap = (i_cnt >= cap_eff);
  assign g_wait = (gw_cnt != '0);

  // Request decision
  always_comb begin
    item_req = '0;
    pw_req   = '0;
    gw_req   = '0;
    n        = 2'd1;
    k0       = KIND_REJECT;
    t0       = tag_q;
    d0       = '0;
    f0       = 1'b0;
    k1       = KIND_GET;
    t1       = gw_head;
    d1       = data_q;
    case (type_q)
      REQ_PUT: begin
        if ((at_cap && (pw_cnt == PC_W'(PRODUCER_MAX))) ||
            (i_cnt == IC_W'(STORE_DEPTH))) begin
          n = 2'd1;
        end else if (at_cap) begin
          // put waits for a get to make room
          item_req.push = 1'b1;
          pw_req.push   = 1'b1;
          n             = 2'd0;
        end else if (g_wait) begin
          // queue empty: item goes straight to the oldest waiting get
          gw_req.pop = 1'b1;
          k0         = KIND_PUT;
          n          = 2'd2;
        end else begin
          item_req.push = 1'b1;
          k0            = KIND_PUT;
          n             = 2'd1;
        end
      end
      REQ_GET: begin
        if ((i_cnt == '0) || g_wait) begin
          if (gw_cnt == GC_W'(CONSUMER_MAX)) begin
            n = 2'd1;
          end else begin
            gw_req.push = 1'b1;
            n           = 2'd0;
          end
        end else begin
          item_req.pop = 1'b1;
          k0           = KIND_GET;
          d0           = item_head;
          k1           = KIND_PUT;
          t1           = pw_head;
          d1           = '0;
          if (pw_cnt != '0) begin
            pw_req.pop = 1'b1;
            n          = 2'd2;
          end else begin
            n = 2'd1;
          end
        end
      end
      REQ_PEEK: begin
        k0 = KIND_PEEK;
        n  = 2'd1;
        if ((i_cnt != '0) && !g_wait) begin
          d0 = item_head;
          f0 = 1'b1;
        end
      end
      default: begin
        n = 2'd1;
      end
    endcase
  end

  // State changes only when the request is taken
  assign item_cmd = fire ? item_req : '0;
  assign pw_cmd   = fire ? pw_req : '0;
  assign gw_cmd   = fire ? gw_req : '0;

  assign res_n = fire ? n : 2'd0;
  assign res0  = {k0, t0, d0, f0, (n == 2'd1)};
  assign res1  = {k1, t1, d1, 1'b0, 1'b1};

  bbq_ring #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_items (
    .clk       (clk),
    .rst       (rst),
    .cmd       (item_cmd),
    .push_data (data_q),
    .head_data (item_head),
    .count     (i_cnt)
  );

  bbq_ring #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (PRODUCER_MAX)
  ) u_put_waiters (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pw_cmd),
    .push_data (tag_q),
    .head_data (pw_head),
    .count     (pw_cnt)
  );

  bbq_ring #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (CONSUMER_MAX)
  ) u_get_waiters (
    .clk       (clk),
    .rst       (rst),
    .cmd       (gw_cmd),
    .push_data (tag_q),
    .head_data (gw_head),
    .count     (gw_cnt)
  );

endmodule

### hw/rtl/bounded_blocking_queue.sv
// ----------------------------------------------------------------------------
// bounded_blocking_queue: bounded FIFO with waiting producers and consumers
// Requests (put, get, peek) come in on req, results leave on res, and the
// capacity register is written on cfg.
//
// Usage:
//   req: one request per handshake. A put stores its item; when the queue
//     already holds capacity items its tag waits and completes later, when
//     a get frees a slot. A get with nothing to take waits in turn and is
//     served by the next put. A peek shows the head item.
//   res: zero, one or two results per request; last_result marks the final
//     one. Full waiter queues and unknown codes give a reject result.
//   cfg: capacity, always ready; write it only while the block is idle.
// Timing: a request is registered, decided against the rings, and its
//   results are written to the result buffer, which offers them on res. One
//   request is taken per cycle while the four-entry result buffer has two
//   free slots; a pair of results drains at one per cycle while res is ready.
// Reset: queue and waiter lists empty, capacity 16, result buffer empty.
// Stall: a stalled res fills the result buffer, then req ready drops.
// ----------------------------------------------------------------------------
module bounded_blocking_queue
  import bbq_pkg::*;
#(
  parameter int QUEUE_MAX    = 16,
  parameter int PRODUCER_MAX = 8,
  parameter int CONSUMER_MAX = 8,
  parameter int DATA_WIDTH   = 64,
  parameter int TAG_WIDTH    = 8
) (
  input  logic     clk,
  input  logic     rst,
  bbq_req_if.sink  req,
  bbq_res_if.source res,
  bbq_cfg_if.sink  cfg
);

  localparam int RES_W = DATA_WIDTH + TAG_WIDTH + 4;

  logic [CAP_W-1:0] capacity;
  logic             room;
  logic [1:0]       res_n;
  logic [RES_W-1:0] res0;
  logic [RES_W-1:0] res1;
  logic [RES_W-1:0] out_data;

  // Capacity register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.capacity;
    end
  end

  bbq_ctrl #(
    .QUEUE_MAX    (QUEUE_MAX),
    .PRODUCER_MAX (PRODUCER_MAX),
    .CONSUMER_MAX (CONSUMER_MAX),
    .DATA_WIDTH   (DATA_WIDTH),
    .TAG_WIDTH    (TAG_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .item_data (req.item_data),
    .op_tag    (req.op_tag),
    .room      (room),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  bbq_res_fifo #(
    .WIDTH (RES_W)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_n      (res_n),
    .wr0       (res0),
    .wr1       (res1),
    .room      (room),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  // Unpack result entry
  assign res.result_kind = out_data[RES_W-1 -: 2];
  assign res.result_tag  = out_data[DATA_WIDTH+TAG_WIDTH+1 -: TAG_WIDTH];
  assign res.result_data = out_data[DATA_WIDTH+1 -: DATA_WIDTH];
  assign res.peek_found  = out_data[1];
  assign res.last_result = out_data[0];

endmodule

### sim/bounded_blocking_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_blocking_queue_tb: self-checking bench for the bounded blocking queue
// Puts, gets and peeks go in on the request channel; a queue model predicts
// each result item and every result is checked against it in order. Covers
// parked puts and gets, waiter overflow, capacity settings and back-pressure.
// ----------------------------------------------------------------------------
module bounded_blocking_queue_tb;
  import bbq_pkg::*;

  localparam int QUEUE_MAX    = 16;
  localparam int PRODUCER_MAX = 8;
  localparam int CONSUMER_MAX = 8;
  localparam int DATA_W       = 64;
  localparam int TAG_W        = 8;
  localparam int STORE_DEPTH  = QUEUE_MAX + PRODUCER_MAX;

  // Fourth request code, has no name in the package
  localparam logic [1:0] REQ_BAD = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    result_kind_t      kind;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
    logic              found;
    logic              last;
  } queue_result_t;

  logic clk;
  logic rst;

  bbq_req_if #(.DATA_WIDTH(DATA_W), .TAG_WIDTH(TAG_W)) req_ch ();
  bbq_res_if #(.DATA_WIDTH(DATA_W), .TAG_WIDTH(TAG_W)) res_ch ();
  bbq_cfg_if cfg_ch ();

  bounded_blocking_queue #(
    .QUEUE_MAX   (QUEUE_MAX),
    .PRODUCER_MAX(PRODUCER_MAX),
    .CONSUMER_MAX(CONSUMER_MAX),
    .DATA_WIDTH  (DATA_W),
    .TAG_WIDTH   (TAG_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Model state: stored items, parked put and get tags, capacity register
  logic [DATA_W-1:0] held_items[$];
  logic [TAG_W-1:0]  parked_put_tags[$];
  logic [TAG_W-1:0]  parked_get_tags[$];
  logic [CAP_W-1:0]  capacity_setting;
  queue_result_t     awaited_results[$];

  int send_idle_pct = 15;
  int recv_idle_pct = 58;
  bit stall_on;
  event hold_results;

  int unsigned cycle_count;
  int mismatch_count;
  int requests_sent;
  int results_checked;
  int capacity_writes;
  int rejects_seen;
  int peeks_found;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             awaited_results.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------

  function automatic int effective_capacity();
    if (capacity_setting == 0) return 1;
    if (capacity_setting > QUEUE_MAX) return QUEUE_MAX;
    return int'(capacity_setting);
  endfunction

  function automatic queue_result_t make_result(input result_kind_t kind,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [DATA_W-1:0] data,
                                                input logic found);
    queue_result_t r;
    r.kind  = kind;
    r.tag   = tag;
    r.data  = data;
    r.found = found;
    r.last  = 1'b0;
    return r;
  endfunction

  // Apply one accepted request to the model and queue the results it causes
  function automatic void predict_request(input logic [1:0] code,
                                          input logic [DATA_W-1:0] payload,
                                          input logic [TAG_W-1:0] tag);
    queue_result_t outs[$];
    logic [DATA_W-1:0] taken;
    bit at_cap;
    at_cap = held_items.size() >= effective_capacity();
    case (code)
      REQ_PUT: begin
        if ((at_cap && parked_put_tags.size() >= PRODUCER_MAX) ||
            held_items.size() >= STORE_DEPTH) begin
          outs.push_back(make_result(KIND_REJECT, tag, '0, 1'b0));
        end else begin
          held_items.push_back(payload);
          if (at_cap) parked_put_tags.push_back(tag);
          else outs.push_back(make_result(KIND_PUT, tag, '0, 1'b0));
          // a parked get takes the head item straight away
          if (parked_get_tags.size() > 0) begin
            taken = held_items.pop_front();
            outs.push_back(make_result(KIND_GET, parked_get_tags.pop_front(), taken, 1'b0));
          end
        end
      end
      REQ_GET: begin
        if (held_items.size() == 0 || parked_get_tags.size() > 0) begin
          if (parked_get_tags.size() >= CONSUMER_MAX)
            outs.push_back(make_result(KIND_REJECT, tag, '0, 1'b0));
          else
            parked_get_tags.push_back(tag);
        end else begin
          taken = held_items.pop_front();
          outs.push_back(make_result(KIND_GET, tag, taken, 1'b0));
          // freed slot releases the oldest parked put
          if (parked_put_tags.size() > 0)
            outs.push_back(make_result(KIND_PUT, parked_put_tags.pop_front(), '0, 1'b0));
        end
      end
      REQ_PEEK: begin
        if (held_items.size() == 0 || parked_get_tags.size() > 0)
          outs.push_back(make_result(KIND_PEEK, tag, '0, 1'b0));
        else
          outs.push_back(make_result(KIND_PEEK, tag, held_items[0], 1'b1));
      end
      default: begin
        outs.push_back(make_result(KIND_REJECT, tag, '0, 1'b0));
      end
    endcase
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) awaited_results.push_back(outs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, hold-off, in-order checking
  // ---------------------------------------------------------------------------

  task automatic check_result();
    queue_result_t want;
    results_checked++;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("ERROR: unexpected result kind %0d tag %0d data %h", res_ch.result_kind,
                 res_ch.result_tag, res_ch.result_data);
    end else begin
      want = awaited_results.pop_front();
      if (want.kind == KIND_REJECT) rejects_seen++;
      if (want.found) peeks_found++;
      if (res_ch.result_kind !== want.kind || res_ch.result_tag !== want.tag ||
          res_ch.result_data !== want.data || res_ch.peek_found !== want.found ||
          res_ch.last_result !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("ERROR: result %0d expected kind %0d tag %0d data %h found %0d last %0d",
                   results_checked, want.kind, want.tag, want.data, want.found, want.last);
          $display("       got kind %0d tag %0d data %h found %0d last %0d",
                   res_ch.result_kind, res_ch.result_tag, res_ch.result_data,
                   res_ch.peek_found, res_ch.last_result);
        end
      end
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result();
      res_ch.ready <= !stall_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    stall_on <= 1'b0;
    forever begin
      @(hold_results);
      stall_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_on <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DATA_W-1:0] random_payload();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item; valid stays high afterwards unless a gap lowers it
  task automatic send_request(input logic [1:0] code, input logic [DATA_W-1:0] payload,
                              input logic [TAG_W-1:0] tag);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= code;
    req_ch.item_data <= payload;
    req_ch.op_tag    <= tag;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(code, payload, tag);
    requests_sent++;
  endtask

  // Stop sending and wait for every awaited result, then let the pipe empty
  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    capacity_setting = value;
    capacity_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset capacity: empty peeks, parked get served by a put, extremes, bad code
  task automatic test_basic_requests();
    send_request(REQ_PEEK, '0, 8'd10);
    send_request(REQ_GET, '0, 8'd1);
    send_request(REQ_PEEK, '0, 8'd2);
    send_request(REQ_PUT, '1, 8'd255);
    send_request(REQ_PUT, '0, 8'd0);
    send_request(REQ_PUT, 64'h8000_0000_0000_0001, 8'h80);
    send_request(REQ_PEEK, '1, 8'h7e);
    send_request(REQ_BAD, '1, 8'h7f);
    send_request(REQ_GET, '1, 8'd3);
    send_request(REQ_GET, '0, 8'd4);
    send_request(REQ_GET, '0, 8'd5);
    send_request(REQ_PUT, 64'h5555_aaaa_0f0f_f0f0, 8'haa);
    settle_idle();
  endtask

  // Capacity 1: puts park until the producer list overflows, gets release them
  task automatic test_put_waiter_overflow();
    write_capacity(5'd1);
    for (int i = 0; i < PRODUCER_MAX + 2; i++)
      send_request(REQ_PUT, random_payload(), TAG_W'(8'h10 + i));
    for (int i = 0; i < PRODUCER_MAX + 1; i++)
      send_request(REQ_GET, random_payload(), TAG_W'(8'h20 + i));
    settle_idle();
  endtask

  // Empty queue: gets park until the consumer list overflows, puts serve them
  task automatic test_get_waiter_overflow();
    for (int i = 0; i < CONSUMER_MAX + 1; i++)
      send_request(REQ_GET, '0, TAG_W'(8'h30 + i));
    send_request(REQ_PEEK, '0, 8'h3f);
    for (int i = 0; i < CONSUMER_MAX; i++)
      send_request(REQ_PUT, random_payload(), TAG_W'(8'h40 + i));
    settle_idle();
  endtask

  // Receiver holds off while the sender keeps offering, so the block stalls
  task automatic test_receiver_hold_off();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    -> hold_results;
    for (int i = 0; i < 30; i++) begin
      if (i % 4 == 3) send_request(REQ_GET, '0, TAG_W'($urandom_range(255)));
      else send_request(REQ_PUT, random_payload(), TAG_W'($urandom_range(255)));
    end
    send_idle_pct = saved_pct;
    settle_idle();
  endtask

  // Sender pauses mid-stream until every result is back
  task automatic test_sender_pause();
    repeat (2) begin
      for (int i = 0; i < 8; i++)
        send_request((i % 2 == 0) ? REQ_PUT : REQ_GET, random_payload(),
                     TAG_W'($urandom_range(255)));
      settle_idle();
    end
  endtask

  // Random bursts of one request kind; capacity changes half way through
  task automatic run_traffic(input int send_pct, input int recv_pct,
                             input logic [CAP_W-1:0] cap_a, input logic [CAP_W-1:0] cap_b,
                             input int n_items);
    int sent;
    int run_len;
    int pick;
    bit switched;
    logic [1:0] code;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    switched = 1'b0;
    settle_idle();
    write_capacity(cap_a);
    while (sent < n_items) begin
      if (!switched && sent >= n_items / 2) begin
        settle_idle();
        write_capacity(cap_b);
        switched = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) code = REQ_PUT;
      else if (pick < 85) code = REQ_GET;
      else if (pick < 95) code = REQ_PEEK;
      else code = REQ_BAD;
      // mostly short runs, now and then a long one to reach the list limits
      if (code == REQ_BAD) run_len = 1;
      else if ($urandom_range(5) == 0) run_len = $urandom_range(14, 6);
      else run_len = $urandom_range(4, 1);
      repeat (run_len) begin
        send_request(code, random_payload(), TAG_W'($urandom_range(255)));
        sent++;
      end
    end
    settle_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_PUT;
    req_ch.item_data <= '0;
    req_ch.op_tag    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.capacity  <= CAP_RESET;
    capacity_setting = CAP_RESET;
    mismatch_count   = 0;
    requests_sent    = 0;
    results_checked  = 0;
    capacity_writes  = 0;
    rejects_seen     = 0;
    peeks_found      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_requests();
    test_put_waiter_overflow();
    test_get_waiter_overflow();
    test_receiver_hold_off();
    test_sender_pause();
    run_traffic(15, 58, 5'd0, 5'd16, 100);
    run_traffic(58, 15, 5'd31, 5'd5, 100);
    run_traffic(0, 0, 5'd17, 5'($urandom_range(16, 1)), 100);

    $display("Run covered %0d requests and %0d results over %0d capacity writes",
             requests_sent, results_checked, capacity_writes);
    $display("Results included %0d rejections and %0d peeks that found an item",
             rejects_seen, peeks_found);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/bbq_pkg.sv
hw/rtl/bbq_ifs.sv
hw/rtl/bbq_ram.sv
hw/rtl/bbq_ring.sv
hw/rtl/bbq_res_fifo.sv
hw/rtl/bbq_ctrl.sv
hw/rtl/bounded_blocking_queue.sv
sim/bounded_blocking_queue_tb.sv
